FILE: hw/rtl/ping_latency_statistics_defines.svh
// Assertion macros for the ping latency statistics block.
// Used by ping_latency_statistics; no other dependencies.
`ifndef PING_LATENCY_STATISTICS_DEFINES_SVH
`define PING_LATENCY_STATISTICS_DEFINES_SVH
`ifndef SYNTHESIS
`define PLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLS_ASSERT(label, clk, rst, prop, msg)
`define PLS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/pls_pkg.sv
// Package for the ping latency statistics block: opcodes and constants.
// No dependencies.
package pls_pkg;
  localparam int unsigned MaxPingsDefault = 256;
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_PING   = 2'd1;
  localparam logic [1:0] OP_PONG   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;
  localparam int unsigned StatCount = 18;
  localparam logic [4:0] STAT_LAST = 5'd17;

  // Percentile in percent for a report slot from 9 to 17.
  function automatic logic [6:0] pct_of(input logic [3:0] k);
    logic [6:0] p;
    begin
      case (k)
        4'd0: p = 7'd1;
        4'd1: p = 7'd5;
        4'd2: p = 7'd10;
        4'd3: p = 7'd25;
        4'd4: p = 7'd50;
        4'd5: p = 7'd75;
        4'd6: p = 7'd90;
        4'd7: p = 7'd95;
        default: p = 7'd99;
      endcase
      return p;
    end
  endfunction
endpackage

FILE: hw/rtl/ping_latency_statistics.sv
// Ping latency statistics engine, top level.
// Depends on pls_pkg and ping_latency_statistics_defines.svh.
//
// Channel   Direction  Handshake               Fields
// command   in         start & !busy           opcode ping_seq time_us elapsed_ms
// config    in         ping_total_we           ping_total_wdata
// report    out        stat_valid (one cycle)  stat_index stat_value last_stat
//
// Ping registers the command, then writes the stamp; pong steps through read, check,
// reciprocal multiply for the divide by 1000, and write. A ping past the count or a pong
// out of range is ignored and leaves the block idle. Start sweeps the stamp memory; reset runs
// the same sweep. Finish: insertion sort, a sum of the samples, up to three serial divides
// and a read for each percentile; busy is high throughout.
// The receiver cannot stall; results come one per strobe cycle.
`include "ping_latency_statistics_defines.svh"
module ping_latency_statistics #(
  parameter int unsigned MAX_PINGS = pls_pkg::MaxPingsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] ping_seq,
  input  logic [31:0] time_us,
  input  logic [31:0] elapsed_ms,
  input  logic        ping_total_we,
  input  logic [8:0]  ping_total_wdata,
  output logic        stat_valid,
  output logic [4:0]  stat_index,
  output logic [31:0] stat_value,
  output logic        last_stat
);
  import pls_pkg::*;

  localparam int AW = $clog2(MAX_PINGS);
  localparam int CW = $clog2(MAX_PINGS + 1);

  // Reciprocals for the divides by constants; exact over the operand ranges used.
  localparam logic [63:0] Ms1000Recip = 64'd274877907;
  localparam int          Ms1000Shift = 38;
  localparam logic [63:0] Pct100Recip = 64'd167773;
  localparam int          Pct100Shift = 24;

  // State codes.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_PONG_RD = 5'd2;
  localparam logic [4:0] S_PONG_CK = 5'd3;
  localparam logic [4:0] S_DIV    = 5'd4;
  localparam logic [4:0] S_PONG_WR = 5'd5;
  localparam logic [4:0] S_SO_OUT = 5'd6;
  localparam logic [4:0] S_SO_KEY = 5'd7;
  localparam logic [4:0] S_SO_RD  = 5'd8;
  localparam logic [4:0] S_SO_CMP = 5'd9;
  localparam logic [4:0] S_SUM_RD = 5'd10;
  localparam logic [4:0] S_SUM_AC = 5'd11;
  localparam logic [4:0] S_EMIT   = 5'd12;
  localparam logic [4:0] S_EDIV   = 5'd13;
  localparam logic [4:0] S_ERD    = 5'd14;
  localparam logic [4:0] S_EWAIT  = 5'd15;
  localparam logic [4:0] S_EOUT   = 5'd16;
  localparam logic [4:0] S_PING   = 5'd17;
  localparam logic [4:0] S_MUL    = 5'd18;
  localparam logic [4:0] S_PONG_MUL = 5'd19;

  logic [4:0] state;
  logic [8:0] ping_total;
  logic [CW-1:0] next_ping, pong_total, sample_total;

  // Latched command.
  logic [15:0] seq_q;
  logic [31:0] time_q, elapsed_q;

  // Stamp memory and sample store.
  logic [31:0] stamp_mem [MAX_PINGS];
  logic [15:0] rtt_mem [MAX_PINGS];
  logic [31:0] stamp_rd;
  logic [15:0] rtt_rd;
  logic        stamp_we;
  logic [AW-1:0] stamp_wa, stamp_ra;
  logic [31:0] stamp_wd;
  logic        rtt_we;
  logic [AW-1:0] rtt_wa, rtt_ra;
  logic [15:0] rtt_wd;

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= stamp_wd;
    end
    stamp_rd <= stamp_mem[stamp_ra];
  end

  always_ff @(posedge clk) begin
    if (rtt_we) begin
      rtt_mem[rtt_wa] <= rtt_wd;
    end
    rtt_rd <= rtt_mem[rtt_ra];
  end

  // Shared restoring divider: 32-bit dividend by 32-bit divisor, one bit a cycle.
  logic [31:0] dv_q, dv_d;
  logic [32:0] dv_r;
  logic [5:0]  dv_cnt;
  logic [32:0] dv_trial;
  assign dv_trial = {dv_r[31:0], dv_q[31]} - {1'b0, dv_d};

  // Working registers.
  logic [CW-1:0] cnt;      // clear pointer, sort i, sum k
  logic [CW-1:0] jj;       // sort j
  logic [15:0]   key;
  logic [31:0]   acc;
  logic [4:0]    sidx;
  logic [15:0]   min_v;
  logic [CW-1:0] n_m1;
  logic [31:0]   mul_a;
  logic [AW-1:0] rd_idx;   // sample read index for the max and percentiles

  logic [CW-1:0] eff;
  assign eff = (32'(ping_total) > MAX_PINGS) ? CW'(MAX_PINGS) : CW'(ping_total);

  logic [CW-1:0] lost;
  assign lost = next_ping - pong_total;

  assign busy = (state != S_IDLE);

  // Memory port control.
  always_comb begin
    stamp_we = 1'b0;
    stamp_wa = '0;
    stamp_wd = '0;
    stamp_ra = seq_q[AW-1:0];
    rtt_we = 1'b0;
    rtt_wa = '0;
    rtt_wd = '0;
    rtt_ra = '0;
    case (state)
      S_CLEAR: begin
        stamp_we = 1'b1;
        stamp_wa = cnt[AW-1:0];
      end
      S_PING: begin
        stamp_we = 1'b1;
        stamp_wa = next_ping[AW-1:0];
        stamp_wd = time_q;
      end
      S_PONG_WR: begin
        stamp_we = 1'b1;
        stamp_wa = seq_q[AW-1:0];
        rtt_we = 1'b1;
        rtt_wa = sample_total[AW-1:0];
        rtt_wd = (dv_q[15:0] == 16'd0) ? 16'd1 : dv_q[15:0];
      end
      S_SO_OUT: rtt_ra = cnt[AW-1:0];
      S_SO_RD:  rtt_ra = AW'(jj - CW'(1));
      S_SO_CMP: begin
        if (jj != '0 && rtt_rd > key) begin
          rtt_we = 1'b1;
          rtt_wa = jj[AW-1:0];
          rtt_wd = rtt_rd;
        end else begin
          rtt_we = 1'b1;
          rtt_wa = jj[AW-1:0];
          rtt_wd = key;
        end
      end
      S_SUM_RD: rtt_ra = cnt[AW-1:0];
      S_ERD:    rtt_ra = rd_idx;
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    stat_valid <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      ping_total <= '0;
      next_ping <= '0;
      pong_total <= '0;
      sample_total <= '0;
      cnt <= '0;
    end else begin
      if (ping_total_we) begin
        ping_total <= ping_total_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            seq_q <= ping_seq;
            time_q <= time_us;
            elapsed_q <= elapsed_ms;
            case (opcode)
              OP_START: begin
                cnt <= '0;
                next_ping <= '0;
                pong_total <= '0;
                sample_total <= '0;
                state <= S_CLEAR;
              end
              OP_PING: begin
                if (next_ping < eff) state <= S_PING;
              end
              OP_PONG: begin
                if (ping_seq < 16'(eff)) state <= S_PONG_RD;
              end
              default: begin
                cnt <= (sample_total > CW'(1)) ? CW'(1) : '0;
                n_m1 <= sample_total - CW'(1);
                state <= (sample_total > CW'(1)) ? S_SO_OUT : S_SUM_RD;
                acc <= '0;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (cnt == CW'(MAX_PINGS - 1)) state <= S_IDLE;
          cnt <= cnt + CW'(1);
        end
        S_PING: begin
          next_ping <= next_ping + CW'(1);
          state <= S_IDLE;
        end
        S_PONG_RD: state <= S_PONG_CK;
        S_PONG_CK: begin
          if (stamp_rd == '0 || sample_total >= CW'(MAX_PINGS)) begin
            state <= S_IDLE;
          end else begin
            dv_q <= time_q - stamp_rd;
            state <= S_PONG_MUL;
          end
        end
        // Divide the microsecond difference by 1000 with a reciprocal multiply.
        S_PONG_MUL: begin
          dv_q <= 32'((64'(dv_q) * Ms1000Recip) >> Ms1000Shift);
          state <= S_PONG_WR;
        end
        S_DIV: begin
          if (dv_trial[32]) begin
            dv_r <= {dv_r[31:0], dv_q[31]};
            dv_q <= {dv_q[30:0], 1'b0};
          end else begin
            dv_r <= dv_trial;
            dv_q <= {dv_q[30:0], 1'b1};
          end
          dv_cnt <= dv_cnt + 6'd1;
          if (dv_cnt == 6'd31) begin
            state <= S_EOUT;
          end
        end
        S_PONG_WR: begin
          sample_total <= sample_total + CW'(1);
          pong_total <= pong_total + CW'(1);
          state <= S_IDLE;
        end
        // Insertion sort: fetch key at index cnt.
        S_SO_OUT: state <= S_SO_KEY;
        S_SO_KEY: begin
          key <= rtt_rd;
          jj <= cnt;
          state <= S_SO_RD;
        end
        S_SO_RD: state <= S_SO_CMP;
        S_SO_CMP: begin
          if (jj != '0 && rtt_rd > key) begin
            jj <= jj - CW'(1);
            state <= S_SO_RD;
          end else if (cnt + CW'(1) < sample_total) begin
            cnt <= cnt + CW'(1);
            state <= S_SO_OUT;
          end else begin
            cnt <= '0;
            state <= S_SUM_RD;
          end
        end
        // Sum the sorted samples.
        S_SUM_RD: begin
          if (cnt == sample_total) begin
            sidx <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_SUM_AC;
          end
        end
        S_SUM_AC: begin
          if (cnt == '0) min_v <= rtt_rd;
          acc <= acc + 32'(rtt_rd);
          cnt <= cnt + CW'(1);
          state <= S_SUM_RD;
        end
        // Report: each statistic is formed, then driven for one cycle.
        S_EMIT: begin
          stat_index <= sidx;
          last_stat <= (sidx == STAT_LAST);
          case (sidx)
            5'd0: begin stat_value <= 32'(next_ping); stat_valid <= 1'b1; end
            5'd1: begin stat_value <= 32'(pong_total); stat_valid <= 1'b1; end
            5'd2: begin stat_value <= 32'(lost); stat_valid <= 1'b1; end
            5'd3: begin
              if (next_ping == '0) begin
                stat_value <= '0;
                stat_valid <= 1'b1;
              end else begin
                mul_a <= 32'(lost);
                state <= S_MUL;
              end
            end
            5'd4: begin stat_value <= elapsed_q; stat_valid <= 1'b1; end
            5'd5: begin
              if (next_ping <= CW'(1)) begin
                stat_value <= '0;
                stat_valid <= 1'b1;
              end else begin
                dv_q <= elapsed_q;
                dv_d <= 32'(next_ping - CW'(1));
                dv_r <= '0;
                dv_cnt <= '0;
                state <= S_DIV;
              end
            end
            5'd6: begin
              stat_value <= (sample_total == '0) ? '0 : 32'(min_v);
              stat_valid <= 1'b1;
            end
            5'd7: begin
              if (sample_total == '0) begin
                stat_value <= '0;
                stat_valid <= 1'b1;
              end else begin
                rd_idx <= n_m1[AW-1:0];
                state <= S_ERD;
              end
            end
            5'd8: begin
              if (sample_total == '0) begin
                stat_value <= '0;
                stat_valid <= 1'b1;
              end else begin
                dv_q <= acc;
                dv_d <= 32'(sample_total);
                dv_r <= '0;
                dv_cnt <= '0;
                state <= S_DIV;
              end
            end
            default: begin
              if (sample_total == '0) begin
                stat_value <= '0;
                stat_valid <= 1'b1;
              end else begin
                mul_a <= 32'(n_m1) * 32'(pct_of(4'(sidx - 5'd9)));
                state <= S_MUL;
              end
            end
          endcase
          if (!(state != S_EMIT)) begin
            if ((sidx == 5'd3 && next_ping == '0) || sidx == 5'd0 || sidx == 5'd1 ||
                sidx == 5'd2 || sidx == 5'd4 || (sidx == 5'd5 && next_ping <= CW'(1)) ||
                sidx == 5'd6 || (sidx >= 5'd7 && sample_total == '0)) begin
              sidx <= sidx + 5'd1;
              if (sidx == STAT_LAST) state <= S_IDLE;
            end
          end
        end
        // Loss rate: register the scaled product and divide it by the sent count.
        // Percentiles: divide the product by 100 with a reciprocal multiply.
        S_MUL: begin
          if (sidx == 5'd3) begin
            dv_q <= mul_a * 32'd1000;
            dv_d <= 32'(next_ping);
            dv_r <= '0;
            dv_cnt <= '0;
            state <= S_DIV;
          end else begin
            rd_idx <= AW'((64'(mul_a) * Pct100Recip) >> Pct100Shift);
            state <= S_ERD;
          end
        end
        S_EOUT: begin
          stat_index <= sidx;
          last_stat <= 1'b0;
          stat_value <= {16'd0, dv_q[15:0]};
          stat_valid <= 1'b1;
          sidx <= sidx + 5'd1;
          state <= S_EMIT;
        end
        S_ERD: state <= S_EWAIT;
        S_EWAIT: begin
          stat_index <= sidx;
          last_stat <= (sidx == STAT_LAST);
          stat_value <= 32'(rtt_rd);
          stat_valid <= 1'b1;
          sidx <= sidx + 5'd1;
          state <= (sidx == STAT_LAST) ? S_IDLE : S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLS_ASSERT(a_fin_last, clk, rst, (stat_valid && last_stat) |-> !busy,
              "report did not end after the last statistic")
  `PLS_ASSERT(a_last_idx, clk, rst, (stat_valid && last_stat) |-> stat_index == STAT_LAST,
              "last flag on wrong index")
  `PLS_ASSERT(a_counts, clk, rst, (pong_total <= next_ping) && (sample_total == pong_total),
              "pong count exceeds ping count")
  `PLS_ASSERT(a_no_accept, clk, rst, (state == S_DIV) |-> busy,
              "idle while dividing")
endmodule
